// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SCG_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked on every rising edge, reset included
`define SCG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== src/scg_pkg.sv =====
package scg_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
   localparam int PIXEL_BITS = 16;
   localparam int DIM_BITS   = 11;
   localparam int MAG_BITS   = 21;
   localparam int GRAD_BITS  = MAG_BITS + 1;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int ROOT_STEPS = MAG_BITS;
   localparam int STEP_BITS  = $clog2(ROOT_STEPS);

   // scharr kernel weights
   localparam logic signed [GRAD_BITS-1:0] EDGE_WEIGHT   = GRAD_BITS'(3);
   localparam logic signed [GRAD_BITS-1:0] CENTRE_WEIGHT = GRAD_BITS'(10);

   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_HEIGHT = 1'd1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_OUT,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic load;
      logic grad;
      logic square;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic ignore;
      logic first;
      logic second;
      logic root_busy;
   } status_type;

endpackage

// ===== src/scg_stream_if.sv =====
interface scg_req_if;
   import scg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [PIXEL_BITS-1:0] pixel;
   modport source (output valid, op, pixel, input ready);
   modport sink (input valid, op, pixel, output ready);
endinterface

interface scg_rsp_if;
   import scg_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [MAG_BITS-1:0]  magnitude;
   logic [ADDR_BITS-1:0] col;
   logic [ADDR_BITS-1:0] row;
   logic                 frame_end;
   modport source (output valid, magnitude, col, row, frame_end, input ready);
   modport sink (input valid, magnitude, col, row, frame_end, output ready);
endinterface

// ===== src/scg_isqrt.sv =====
module scg_isqrt
   import scg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SQ_BITS-1:0]  radicand,
   output logic                busy,
   output logic [MAG_BITS-1:0] root
);

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SQ_BITS-1:0]   rad_ff, rad_in;
   logic [MAG_BITS+1:0]  rem_ff, rem_in;
   logic [MAG_BITS-1:0]  root_ff, root_in;
   logic [MAG_BITS+3:0]  cand;
   logic [MAG_BITS+3:0]  trial;

   // one result bit per cycle, restoring digit recurrence
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cand    = {rem_ff, rad_ff[SQ_BITS-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_BITS-3:0], 2'b00};
         if (cand >= trial) begin
            rem_in  = (MAG_BITS+2)'(cand - trial);
            root_in = {root_ff[MAG_BITS-2:0], 1'b1};
         end else begin
            rem_in  = (MAG_BITS+2)'(cand);
            root_in = {root_ff[MAG_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== src/scg_datapath.sv =====
module scg_datapath
   import scg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    req_op,
   input  logic [PIXEL_BITS-1:0]   req_pixel,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]     csr_write_data,
   output logic [MAG_BITS-1:0]     rsp_magnitude,
   output logic [ADDR_BITS-1:0]    rsp_col,
   output logic [ADDR_BITS-1:0]    rsp_row,
   output logic                    rsp_frame_end
);

   // line stores
   logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic [ADDR_BITS-1:0]  col_ff, col_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic [ADDR_BITS-1:0]  drain_ff, drain_in;
   logic [ADDR_BITS-1:0]  clr_ff;
   logic                  second_ff;
   logic                  op_ff;
   logic [PIXEL_BITS-1:0] px_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [PIXEL_BITS-1:0] up_rd_ff, lo_rd_ff;
   logic [PIXEL_BITS-1:0] win_ff [9];
   logic [MAG_BITS-1:0]   ax_ff, ay_ff;
   logic [ADDR_BITS-1:0]  ocol_ff;
   logic [ADDR_BITS-1:0]  orow_ff;
   logic                  ofe_ff;

   logic [DIM_BITS-1:0]   w_used, h_used, w_last;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [PIXEL_BITS-1:0] up_wd, lo_wd;
   logic [PIXEL_BITS-1:0] top, mid, bot;
   logic                  at_last, out_ok, first;
   logic signed [GRAD_BITS-1:0] gx, gy;
   logic [SQ_BITS-1:0]    radicand;
   logic                  root_busy;

   function automatic logic signed [GRAD_BITS-1:0] ext(input logic [PIXEL_BITS-1:0] p);
      ext = $signed({{(GRAD_BITS - PIXEL_BITS){1'b0}}, p});
   endfunction

   function automatic logic [MAG_BITS-1:0] mag(input logic signed [GRAD_BITS-1:0] g);
      logic signed [GRAD_BITS-1:0] a;
      a = (g < 0) ? -g : g;
      mag = a[MAG_BITS-1:0];
   endfunction

   // clamped frame size
   always_comb begin
      w_used = width_ff;
      if (width_ff < DIM_BITS'(3)) w_used = DIM_BITS'(3);
      if (width_ff > DIM_BITS'(MAX_WIDTH)) w_used = DIM_BITS'(MAX_WIDTH);
      h_used = height_ff;
      if (height_ff < DIM_BITS'(3)) h_used = DIM_BITS'(3);
      if (height_ff > DIM_BITS'(MAX_HEIGHT)) h_used = DIM_BITS'(MAX_HEIGHT);
      w_last = w_used - 1'b1;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(MAX_WIDTH);
         height_ff <= DIM_BITS'(MAX_HEIGHT);
      end else if (csr_write_en) begin
         if (csr_index == CSR_IDX_WIDTH) begin
            width_ff <= csr_write_data;
         end else begin
            height_ff <= csr_write_data;
         end
      end
   end

   // item decisions
   assign rd_addr = (req_op == OP_FLUSH) ? drain_ff : col_ff;
   assign at_last = {1'b0, addr_ff} >= w_last;
   assign out_ok  = (op_ff == OP_FLUSH) || (row_ff != '0);
   assign first   = (addr_ff != '0) && out_ok;

   always_comb begin
      status.clear_last = (clr_ff == ADDR_BITS'(MAX_WIDTH - 1));
      status.ignore     = (req_op == OP_FLUSH) ? (row_ff < h_used) : (row_ff >= h_used);
      status.first      = first;
      status.second     = second_ff;
      status.root_busy  = root_busy;
   end

   // column fed to the window
   always_comb begin
      if (op_ff == OP_FLUSH) begin
         top = up_rd_ff;
         mid = lo_rd_ff;
         bot = lo_rd_ff;
      end else begin
         top = (row_ff == DIM_BITS'(1)) ? lo_rd_ff : up_rd_ff;
         mid = lo_rd_ff;
         bot = px_ff;
      end
   end

   // line store write port, shared by the clearing pass
   always_comb begin
      mem_we  = cmd.clear || (cmd.load && (op_ff == OP_PIXEL));
      wr_addr = cmd.clear ? clr_ff : addr_ff;
      up_wd   = cmd.clear ? '0 : lo_rd_ff;
      lo_wd   = cmd.clear ? '0 : px_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[wr_addr] <= up_wd;
         lower_mem[wr_addr] <= lo_wd;
      end
      up_rd_ff <= upper_mem[rd_addr];
      lo_rd_ff <= lower_mem[rd_addr];
   end

   // position counters
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (cmd.load) begin
         if (op_ff == OP_FLUSH) begin
            if (at_last) begin
               drain_in = '0;
               row_in   = '0;
               col_in   = '0;
            end else begin
               drain_in = addr_ff + 1'b1;
            end
         end else if (at_last) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         drain_ff  <= '0;
         clr_ff    <= '0;
         second_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.load) second_ff <= first && at_last;
         else if (cmd.shift) second_ff <= 1'b0;
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_op;
         px_ff   <= req_pixel;
         addr_ff <= rd_addr;
      end
   end

   // window shift and result position
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (addr_ff == '0) begin
            win_ff[3] <= top;
            win_ff[4] <= mid;
            win_ff[5] <= bot;
         end else begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= win_ff[6];
            win_ff[4] <= win_ff[7];
            win_ff[5] <= win_ff[8];
         end
         win_ff[6] <= top;
         win_ff[7] <= mid;
         win_ff[8] <= bot;
         ocol_ff   <= addr_ff - 1'b1;
         orow_ff   <= ADDR_BITS'(row_ff - 1'b1);
         ofe_ff    <= 1'b0;
      end else if (cmd.shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= win_ff[6];
         win_ff[4] <= win_ff[7];
         win_ff[5] <= win_ff[8];
         ocol_ff   <= ocol_ff + 1'b1;
         ofe_ff    <= (op_ff == OP_FLUSH);
      end
   end

   // scharr gradients
   always_comb begin
      gx = EDGE_WEIGHT * (ext(win_ff[6]) - ext(win_ff[0]))
         + CENTRE_WEIGHT * (ext(win_ff[7]) - ext(win_ff[1]))
         + EDGE_WEIGHT * (ext(win_ff[8]) - ext(win_ff[2]));
      gy = EDGE_WEIGHT * (ext(win_ff[2]) - ext(win_ff[0]))
         + CENTRE_WEIGHT * (ext(win_ff[5]) - ext(win_ff[3]))
         + EDGE_WEIGHT * (ext(win_ff[8]) - ext(win_ff[6]));
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         ax_ff <= mag(gx);
         ay_ff <= mag(gy);
      end
   end

   // sum of squares into the root unit
   assign radicand = SQ_BITS'(ax_ff * ax_ff) + SQ_BITS'(ay_ff * ay_ff);

   scg_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.square),
      .radicand (radicand),
      .busy     (root_busy),
      .root     (rsp_magnitude)
   );

   assign rsp_col       = ocol_ff;
   assign rsp_row       = orow_ff;
   assign rsp_frame_end = ofe_ff;

endmodule

// ===== src/scg_ctrl.sv =====
module scg_ctrl
   import scg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && !status.ignore) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = status.first ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            cmd.grad = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (!status.root_busy) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = status.second ? ST_SHIFT : ST_IDLE;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = ST_GRAD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== src/scharr_gradient_magnitude_core.sv =====
// a pixel or flush item with one result passes the load, gradient, square and root
// states before its result is offered; a second result of the same item follows the
// shift, gradient, square and root states after the first is taken; items are taken
// one at a time; an ignored item stays idle, one without result returns after its load
// reset: synchronous, active high; a clearing pass zeroes all 1024 line store entries
// and no item is accepted until it ends (register writes are taken throughout)
module scharr_gradient_magnitude_core
   import scg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   scg_req_if.sink                 req_chan,
   scg_rsp_if.source               rsp_chan,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]     csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   scg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // line stores, window and arithmetic
   scg_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_chan.op),
      .req_pixel      (req_chan.pixel),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_magnitude  (rsp_chan.magnitude),
      .rsp_col        (rsp_chan.col),
      .rsp_row        (rsp_chan.row),
      .rsp_frame_end  (rsp_chan.frame_end)
   );

endmodule

// ===== src/scg_checker.sv =====
`include "assert_macros.svh"

module scg_checker
   import scg_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [MAG_BITS-1:0]  rsp_magnitude,
   input logic [ADDR_BITS-1:0] rsp_col
);

   // held result stays offered
   `SCG_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   // held result keeps its value
   `SCG_ASSERT_CLK(a_mag_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_magnitude))
   `SCG_ASSERT_CLK(a_col_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_col))
   // one item at a time: no new item while a result is offered
   `SCG_ASSERT_ALWAYS(a_excl, clock, !(req_ready && rsp_valid))
   // a result never appears the cycle after an item is taken
   `SCG_ASSERT_CLK(a_no_early, clock, reset, req_valid && req_ready |=> !rsp_valid)

endmodule

bind scharr_gradient_magnitude_core scg_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_magnitude (rsp_chan.magnitude),
   .rsp_col       (rsp_chan.col)
);
